@@ src/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types, widths and helpers for the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
package rmq_pkg;

  // field format
  localparam int FIELD_W       = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAG_W         = FIELD_W + 1;
  localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  // slot that carries the root-derived component
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2,
    AX_W = 2'd3
  } axis_t;

  // one input matrix
  typedef struct packed {
    logic signed [FIELD_W-1:0] e00;
    logic signed [FIELD_W-1:0] e01;
    logic signed [FIELD_W-1:0] e02;
    logic signed [FIELD_W-1:0] e10;
    logic signed [FIELD_W-1:0] e11;
    logic signed [FIELD_W-1:0] e12;
    logic signed [FIELD_W-1:0] e20;
    logic signed [FIELD_W-1:0] e21;
    logic signed [FIELD_W-1:0] e22;
    logic signed [FIELD_W-1:0] e33;
  } mat_t;

  // numerators of the three divided components, sign and magnitude
  typedef struct packed {
    axis_t                  main_axis;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
  } num_t;

  // divider results for the three lanes
  typedef struct packed {
    axis_t                   main_axis;
    logic [2:0]              neg;
    logic [2:0]              ovf;
    logic [2:0][FIELD_W-1:0] quo;
  } div_res_t;

  // signed width of the trace and radicand
  function automatic int trace_w(input int frac);
    return (frac + 2 > FIELD_W + 2) ? frac + 2 : FIELD_W + 2;
  endfunction

  // width of the shifted radicand, rounded up to even
  function automatic int sq_w(input int frac);
    return ((trace_w(frac) - 1 + frac + 1) / 2) * 2;
  endfunction

  function automatic int root_w(input int frac);
    return sq_w(frac) / 2;
  endfunction

  // working width of the divider remainder
  function automatic int div_w(input int frac);
    return (MAG_W + frac > root_w(frac) + 1 + FIELD_W) ?
           MAG_W + frac : root_w(frac) + 1 + FIELD_W;
  endfunction

  // sign and magnitude of a signed numerator
  function automatic logic [MAG_W:0] to_sm(input logic signed [MAG_W-1:0] n);
    logic [MAG_W-1:0] mag;
    mag = n[MAG_W-1] ? MAG_W'(-n) : MAG_W'(n);
    return {n[MAG_W-1], mag};
  endfunction

endpackage

@@ src/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq_if
// request channels of the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_0_0;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_0_1;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_0_2;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_1_0;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_1_1;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_1_2;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_2_0;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_2_1;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_2_2;
  logic signed [rmq_pkg::FIELD_W-1:0] elem_3_3;

  modport source (
    output valid, elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2,
           elem_2_0, elem_2_1, elem_2_2, elem_3_3,
    input  ready
  );
  modport sink (
    input  valid, elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2,
           elem_2_0, elem_2_1, elem_2_2, elem_3_3,
    output ready
  );
endinterface

interface rmq_out_if;
  logic valid;
  logic ready;
  logic signed [rmq_pkg::FIELD_W-1:0] quat_x;
  logic signed [rmq_pkg::FIELD_W-1:0] quat_y;
  logic signed [rmq_pkg::FIELD_W-1:0] quat_z;
  logic signed [rmq_pkg::FIELD_W-1:0] quat_w;
  logic                               degenerate;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
    input  ready
  );
  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, degenerate,
    output ready
  );
endinterface

@@ src/rmq_prep.sv @@
// ----------------------------------------------------------------------------
// rmq_prep
// trace test, axis choice, radicand and numerator selection (one stage)
// ----------------------------------------------------------------------------
module rmq_prep #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  rmq_pkg::mat_t                                   mat,
  output logic                                            out_valid,
  output logic [rmq_pkg::trace_w(FRAC_BITS)-2:0]          rad,
  output rmq_pkg::num_t                                   num
);

  localparam int TW = rmq_pkg::trace_w(FRAC_BITS);
  localparam int MW = rmq_pkg::MAG_W;
  localparam logic signed [TW-1:0] ONE = {{(TW-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [TW-1:0] d00, d11, d22, d33, tr, rad_x, rad_y, rad_z, rad_sel;
  logic signed [MW-1:0] a01, a02, a10, a12, a20, a21;
  logic signed [MW-1:0] n0, n1, n2;
  logic                 trace_br;
  rmq_pkg::axis_t       axis;
  logic [MW:0]          sm0, sm1, sm2;

  logic                 valid_r;
  logic [TW-2:0]        rad_r;
  rmq_pkg::num_t        num_r;

  // widened diagonal and off-diagonal elements
  assign d00 = TW'(mat.e00);
  assign d11 = TW'(mat.e11);
  assign d22 = TW'(mat.e22);
  assign d33 = TW'(mat.e33);
  assign a01 = MW'(mat.e01);
  assign a02 = MW'(mat.e02);
  assign a10 = MW'(mat.e10);
  assign a12 = MW'(mat.e12);
  assign a20 = MW'(mat.e20);
  assign a21 = MW'(mat.e21);

  // trace and per-axis radicands
  assign tr       = d00 + d11 + d22 + d33;
  assign trace_br = (tr >= ONE);
  assign rad_x    = d00 - d11 - d22 + ONE;
  assign rad_y    = d11 - d22 - d00 + ONE;
  assign rad_z    = d22 - d00 - d11 + ONE;

  // branch and axis selection, ties stay on the earlier axis
  always_comb begin
    logic x_ge_y;
    logic z_gt;
    x_ge_y = (mat.e00 >= mat.e11);
    z_gt   = x_ge_y ? (mat.e22 > mat.e00) : (mat.e22 > mat.e11);
    if (trace_br) begin
      axis = rmq_pkg::AX_W;
    end else if (z_gt) begin
      axis = rmq_pkg::AX_Z;
    end else if (x_ge_y) begin
      axis = rmq_pkg::AX_X;
    end else begin
      axis = rmq_pkg::AX_Y;
    end
  end

  // radicand and numerators by chosen slot
  always_comb begin
    case (axis)
      rmq_pkg::AX_X: begin
        rad_sel = rad_x;
        n0 = a10 + a01;  n1 = a20 + a02;  n2 = a21 - a12;
      end
      rmq_pkg::AX_Y: begin
        rad_sel = rad_y;
        n0 = a21 + a12;  n1 = a01 + a10;  n2 = a02 - a20;
      end
      rmq_pkg::AX_Z: begin
        rad_sel = rad_z;
        n0 = a02 + a20;  n1 = a12 + a21;  n2 = a10 - a01;
      end
      default: begin
        rad_sel = tr;
        n0 = a21 - a12;  n1 = a02 - a20;  n2 = a10 - a01;
      end
    endcase
  end

  assign sm0 = rmq_pkg::to_sm(n0);
  assign sm1 = rmq_pkg::to_sm(n1);
  assign sm2 = rmq_pkg::to_sm(n2);

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // negative radicand clamps to zero
      rad_r             <= rad_sel[TW-1] ? '0 : rad_sel[TW-2:0];
      num_r.main_axis   <= axis;
      num_r.neg         <= {sm2[MW], sm1[MW], sm0[MW]};
      num_r.mag         <= {sm2[MW-1:0], sm1[MW-1:0], sm0[MW-1:0]};
    end
  end

  assign out_valid = valid_r;
  assign rad       = rad_r;
  assign num       = num_r;

endmodule

@@ src/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [rmq_pkg::trace_w(FRAC_BITS)-2:0]   rad,
  input  rmq_pkg::num_t                            in_num,
  output logic                                     out_valid,
  output logic [rmq_pkg::root_w(FRAC_BITS)-1:0]    root,
  output rmq_pkg::num_t                            out_num
);

  localparam int SQ_W  = rmq_pkg::sq_w(FRAC_BITS);
  localparam int ROOT_W = rmq_pkg::root_w(FRAC_BITS);
  localparam int REM_W = ROOT_W + 2;

  logic                valid_r [ROOT_W+1];
  logic [SQ_W-1:0]     val_r   [ROOT_W+1];
  logic [REM_W-1:0]    rem_r   [ROOT_W+1];
  logic [ROOT_W-1:0]   root_r  [ROOT_W+1];
  rmq_pkg::num_t       num_r   [ROOT_W+1];

  // load stage: scale radicand into the root format
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r[0]  <= SQ_W'(rad) << FRAC_BITS;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      num_r[0]  <= in_num;
    end
  end

  // digit stages: bring down two bits, try subtracting 4*root+1
  for (genvar s = 1; s <= ROOT_W; s++) begin : g_step
    logic [REM_W-1:0] rem_w;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_w = {rem_r[s-1][REM_W-3:0], val_r[s-1][SQ_W-1 -: 2]};
    assign trial = {root_r[s-1], 2'b01};
    assign take  = (rem_w >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r[s]  <= {val_r[s-1][SQ_W-3:0], 2'b00};
        rem_r[s]  <= take ? rem_w - trial : rem_w;
        root_r[s] <= {root_r[s-1][ROOT_W-2:0], take};
        num_r[s]  <= num_r[s-1];
      end
    end
  end

  assign out_valid = valid_r[ROOT_W];
  assign root      = root_r[ROOT_W];
  assign out_num   = num_r[ROOT_W];

endmodule

@@ src/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [rmq_pkg::root_w(FRAC_BITS):0]     in_d,
  input  rmq_pkg::num_t                           in_num,
  output logic                                    out_valid,
  output logic [rmq_pkg::root_w(FRAC_BITS):0]     out_d,
  output rmq_pkg::div_res_t                       res
);

  localparam int QB = rmq_pkg::FIELD_W;
  localparam int DW = rmq_pkg::root_w(FRAC_BITS) + 1;
  localparam int CW = rmq_pkg::div_w(FRAC_BITS);

  logic            valid_r [QB+1];
  logic [DW-1:0]   d_r     [QB+1];
  logic [CW-1:0]   rem_r   [QB+1][3];
  logic [QB-1:0]   quo_r   [QB+1][3];
  logic [2:0]      ovf_r   [QB+1];
  logic [2:0]      neg_r   [QB+1];
  rmq_pkg::axis_t  axis_r  [QB+1];

  logic [CW-1:0]   d_top;

  // quotient must fit in QB bits, else the lane saturates
  assign d_top = CW'(in_d) << QB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
    end
  end

  // load stage
  for (genvar l = 0; l < 3; l++) begin : g_load
    logic [CW-1:0] n_sh;
    assign n_sh = CW'(in_num.mag[l]) << FRAC_BITS;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0][l] <= n_sh;
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= (n_sh >= d_top);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]    <= in_d;
      neg_r[0]  <= in_num.neg;
      axis_r[0] <= in_num.main_axis;
    end
  end

  // quotient bit stages, most significant first
  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [CW-1:0] d_sh;
    assign d_sh = CW'(d_r[s-1]) << (QB - s);

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic take;
      assign take = (rem_r[s-1][l] >= d_sh);
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][l] <= take ? rem_r[s-1][l] - d_sh : rem_r[s-1][l];
          quo_r[s][l] <= {quo_r[s-1][l][QB-2:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[s]    <= d_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        axis_r[s] <= axis_r[s-1];
      end
    end
  end

  assign out_valid     = valid_r[QB];
  assign out_d         = d_r[QB];
  assign res.main_axis = axis_r[QB];
  assign res.neg       = neg_r[QB];
  assign res.ovf       = ovf_r[QB];
  assign res.quo       = {quo_r[QB][2], quo_r[QB][1], quo_r[QB][0]};

endmodule

@@ src/rotation_matrix_to_quaternion_unit.sv @@
// Stages: 1 prep stage, root load + one stage per root bit, divider load + one
// stage per quotient bit, output register. Throughput: one matrix per cycle
// while no finished result is held at the output.
// The whole pipeline advances together and holds while a result waits.
// Reset (rst_n low, synchronous) clears all stage valid bits.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// rotation matrix to quaternion conversion, trace or largest-diagonal method
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  rmq_in_if.sink          in_if,
  rmq_out_if.source       out_if
);

  localparam int FW     = rmq_pkg::FIELD_W;
  localparam int TW     = rmq_pkg::trace_w(FRAC_BITS);
  localparam int ROOT_W = rmq_pkg::root_w(FRAC_BITS);
  localparam int DW     = ROOT_W + 1;

  logic                 adv;
  rmq_pkg::mat_t        mat;
  logic                 prep_valid, sqrt_valid, div_valid;
  logic [TW-2:0]        prep_rad;
  rmq_pkg::num_t        prep_num, sqrt_num;
  logic [ROOT_W-1:0]    sqrt_root;
  logic [DW-1:0]        div_d;
  rmq_pkg::div_res_t    div_res;

  logic [DW-1:0]        main_u;
  logic signed [FW-1:0] main_q;
  logic signed [FW-1:0] lane_q [3];
  logic signed [FW-1:0] qx, qy, qz, qw;
  logic                 degen;

  logic                 out_valid_r;
  logic signed [FW-1:0] qx_r, qy_r, qz_r, qw_r;
  logic                 degen_r;

  // pipeline advances unless a finished result is held
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  assign mat.e00 = in_if.elem_0_0;
  assign mat.e01 = in_if.elem_0_1;
  assign mat.e02 = in_if.elem_0_2;
  assign mat.e10 = in_if.elem_1_0;
  assign mat.e11 = in_if.elem_1_1;
  assign mat.e12 = in_if.elem_1_2;
  assign mat.e20 = in_if.elem_2_0;
  assign mat.e21 = in_if.elem_2_1;
  assign mat.e22 = in_if.elem_2_2;
  assign mat.e33 = in_if.elem_3_3;

  rmq_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_if.valid),
    .mat       (mat),
    .out_valid (prep_valid),
    .rad       (prep_rad),
    .num       (prep_num)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (prep_valid),
    .rad       (prep_rad),
    .in_num    (prep_num),
    .out_valid (sqrt_valid),
    .root      (sqrt_root),
    .out_num   (sqrt_num)
  );

  // divisor is twice the root
  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sqrt_valid),
    .in_d      ({sqrt_root, 1'b0}),
    .in_num    (sqrt_num),
    .out_valid (div_valid),
    .out_d     (div_d),
    .res       (div_res)
  );

  // main component: root / 2 = divisor / 4, saturated
  assign main_u = div_d >> 2;
  assign main_q = ((main_u >> (FW - 1)) != '0) ? rmq_pkg::FIELD_MAX : FW'(main_u);

  // sign and saturate each divided lane
  for (genvar l = 0; l < 3; l++) begin : g_sat
    always_comb begin
      logic [FW-1:0] q;
      q = div_res.quo[l];
      if (!div_res.neg[l]) begin
        lane_q[l] = (div_res.ovf[l] || q[FW-1]) ? rmq_pkg::FIELD_MAX : signed'(q);
      end else if (div_res.ovf[l] || (q[FW-1] && (q[FW-2:0] != '0))) begin
        lane_q[l] = rmq_pkg::FIELD_MIN;
      end else begin
        lane_q[l] = signed'(-q);
      end
    end
  end

  // route lanes to components, zero on a null divisor
  assign degen = (div_d == '0);

  always_comb begin
    case (div_res.main_axis)
      rmq_pkg::AX_X: begin
        qx = main_q;    qy = lane_q[0]; qz = lane_q[1]; qw = lane_q[2];
      end
      rmq_pkg::AX_Y: begin
        qy = main_q;    qz = lane_q[0]; qx = lane_q[1]; qw = lane_q[2];
      end
      rmq_pkg::AX_Z: begin
        qz = main_q;    qx = lane_q[0]; qy = lane_q[1]; qw = lane_q[2];
      end
      default: begin
        qw = main_q;    qx = lane_q[0]; qy = lane_q[1]; qz = lane_q[2];
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r    <= degen ? '0 : qx;
      qy_r    <= degen ? '0 : qy;
      qz_r    <= degen ? '0 : qz;
      qw_r    <= degen ? '0 : qw;
      degen_r <= degen;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.quat_x     = qx_r;
  assign out_if.quat_y     = qy_r;
  assign out_if.quat_z     = qz_r;
  assign out_if.quat_w     = qw_r;
  assign out_if.degenerate = degen_r;

endmodule
